[src/slt_pkg.sv]
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants for structured light triangulation
// Word widths, pipeline depths, command codes and the result item record.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

    localparam int WORD_W          = 32;
    localparam int NUM_WORDS       = 20;
    localparam int CAL_IDX_W       = 5;
    localparam int DEF_COORD_BITS  = 12;
    localparam int DEF_FRAC_BITS   = 16;

    // signed width of det and numerators: 3 terms of 32 x 64 bit products
    localparam int DOT_W           = 99;
    localparam int QUO_W           = 32;

    // register stages ahead of the dividers, and divider latency
    localparam int LEAD_STAGES     = 7;
    localparam int DIV_LAT         = QUO_W + 4;

    localparam logic CMD_LOAD      = 1'b0;
    localparam logic CMD_PIXEL     = 1'b1;

    typedef struct packed {
        logic signed [WORD_W-1:0] x;
        logic signed [WORD_W-1:0] y;
        logic signed [WORD_W-1:0] z;
        logic                     sing;
    } t_result;

    // clamp to the signed 32-bit range
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sh7FFF_FFFF;
        lo = -66'sh8000_0000;
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = -32'sh8000_0000;
        end else begin
            sat32 = v[WORD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

[src/structured_light_triangulation.sv]
// ----------------------------------------------------------------------------
// structured_light_triangulation: camera/projector point reconstruction
// Loads calibration words and turns pixel items into world X, Y, Z.
// ----------------------------------------------------------------------------
// Takes one item per cycle while in_ready is high. A load item (command 0)
// writes a calibration word when accepted with an index below 20 and gives
// no result; a pixel item gives one result, computed by seven arithmetic
// stages (products, row terms, adjugate products, adjugate, split 32 x 64
// products, recombine, dot sums) followed by a 36-stage divider with one
// quotient bit per restoring stage, one per coordinate. A two-entry output
// register and skid stage let the pipe keep accepting while a result waits;
// only when both are full does in_ready drop. Words never loaded read as garbage.
`default_nettype none

module structured_light_triangulation #(
    parameter int COORD_BITS = slt_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = slt_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_command,
    input  wire logic [slt_pkg::CAL_IDX_W-1:0]       i_coef_index,
    input  wire logic signed [slt_pkg::WORD_W-1:0]   i_coef_value,
    input  wire logic [COORD_BITS-1:0]               i_pixel_column,
    input  wire logic [COORD_BITS-1:0]               i_pixel_row,
    input  wire logic signed [slt_pkg::WORD_W-1:0]   i_phase_value,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [slt_pkg::WORD_W-1:0]        o_point_x,
    output logic signed [slt_pkg::WORD_W-1:0]        o_point_y,
    output logic signed [slt_pkg::WORD_W-1:0]        o_point_z,
    output logic                                     o_singular
);
    import slt_pkg::*;

    localparam int UW  = COORD_BITS + 1;
    localparam int MUW = WORD_W + UW + 1;
    localparam int TOT = LEAD_STAGES + DIV_LAT;

    logic en, acc;
    logic r_skid_v;

    assign en         = ~r_skid_v;
    assign o_in_ready = en;
    assign acc        = i_in_valid & o_in_ready;

    // calibration words
    logic signed [WORD_W-1:0] r_cal [NUM_WORDS];

    always_ff @(posedge i_clk) begin
        if (acc && i_command == CMD_LOAD && i_coef_index < CAL_IDX_W'(NUM_WORDS)) begin
            r_cal[i_coef_index] <= i_coef_value;
        end
    end

    // valid bits travel with the data
    logic [TOT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOT-2:0], acc & (i_command == CMD_PIXEL)};
        end
    end

    // stage 1: pixel-scaled and phase-scaled products
    logic [UW-1:0]             u, v;
    logic signed [MUW-1:0]     r1_mu [3];
    logic signed [MUW-1:0]     r1_mv [3];
    logic signed [MUW-1:0]     r1_m11u, r1_m11v;
    logic signed [2*WORD_W-1:0] r1_mp [4];
    logic signed [WORD_W-1:0]  r1_w [12];

    assign u = UW'(i_pixel_column) + UW'(1);
    assign v = UW'(i_pixel_row) + UW'(1);

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r1_mu[j] <= MUW'(r_cal[8+j]) * MUW'($signed({1'b0, u}));
                r1_mv[j] <= MUW'(r_cal[8+j]) * MUW'($signed({1'b0, v}));
            end
            r1_m11u <= MUW'(r_cal[11]) * MUW'($signed({1'b0, u}));
            r1_m11v <= MUW'(r_cal[11]) * MUW'($signed({1'b0, v}));
            for (int j = 0; j < 4; j++) begin
                r1_mp[j] <= (2*WORD_W)'(r_cal[16+j]) * (2*WORD_W)'(i_phase_value);
            end
            for (int j = 0; j < 8; j++) begin
                r1_w[j] <= r_cal[j];
            end
            for (int j = 0; j < 4; j++) begin
                r1_w[8+j] <= r_cal[12+j];
            end
        end
    end

    // stage 2: system rows, rounded and saturated
    logic signed [64:0]       rnd [4];
    logic signed [WORD_W-1:0] r2_c [3][3];
    logic signed [WORD_W-1:0] r2_d [3];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            rnd[j] = (65'(r1_mp[j]) + $signed(65'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r2_c[0][j] <= sat32(66'(r1_w[j]) - 66'(r1_mu[j]));
                r2_c[1][j] <= sat32(66'(r1_w[4+j]) - 66'(r1_mv[j]));
                r2_c[2][j] <= sat32(66'(r1_w[8+j]) - 66'(rnd[j]));
            end
            r2_d[0] <= sat32(66'(r1_m11u) - 66'(r1_w[3]));
            r2_d[1] <= sat32(66'(r1_m11v) - 66'(r1_w[7]));
            r2_d[2] <= sat32(66'(rnd[3]) - 66'(r1_w[11]));
        end
    end

    // stage 3: cofactor products (adjugate is the transposed cofactor matrix)
    logic signed [2*WORD_W-1:0] r3_pa [3][3];
    logic signed [2*WORD_W-1:0] r3_pb [3][3];
    logic signed [WORD_W-1:0]   r3_c0 [3];
    logic signed [WORD_W-1:0]   r3_d  [3];

    for (genvar gi = 0; gi < 3; gi++) begin : g_adj_i
        for (genvar gj = 0; gj < 3; gj++) begin : g_adj_j
            localparam int R1 = (gj + 1) % 3;
            localparam int R2 = (gj + 2) % 3;
            localparam int K1 = (gi + 1) % 3;
            localparam int K2 = (gi + 2) % 3;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r3_pa[gi][gj] <= (2*WORD_W)'(r2_c[R1][K1]) * (2*WORD_W)'(r2_c[R2][K2]);
                    r3_pb[gi][gj] <= (2*WORD_W)'(r2_c[R1][K2]) * (2*WORD_W)'(r2_c[R2][K1]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_c0 <= r2_c[0];
            r3_d  <= r2_d;
        end
    end

    // stage 4: adjugate entries
    logic signed [2*WORD_W-1:0] r4_a [3][3];
    logic signed [WORD_W-1:0]   r4_c0 [3];
    logic signed [WORD_W-1:0]   r4_d  [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r4_a[i][j] <= r3_pa[i][j] - r3_pb[i][j];
                end
            end
            r4_c0 <= r3_c0;
            r4_d  <= r3_d;
        end
    end

    // stage 5: 32 x 64 products split into two 32 x 32 halves
    // group 0 is the determinant, groups 1..3 the X, Y, Z numerators
    logic signed [2*WORD_W:0]   r5_pl [4][3];
    logic signed [2*WORD_W-1:0] r5_ph [4][3];

    for (genvar g = 0; g < 4; g++) begin : g_dot
        for (genvar t = 0; t < 3; t++) begin : g_term
            logic signed [WORD_W-1:0]   coef;
            logic signed [2*WORD_W-1:0] adj;
            if (g == 0) begin : g_det
                assign coef = r4_c0[t];
                assign adj  = r4_a[t][0];
            end else begin : g_num
                assign coef = r4_d[t];
                assign adj  = r4_a[g-1][t];
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r5_pl[g][t] <= (2*WORD_W+1)'(coef)
                                 * (2*WORD_W+1)'($signed({1'b0, adj[WORD_W-1:0]}));
                    r5_ph[g][t] <= (2*WORD_W)'(coef)
                                 * (2*WORD_W)'($signed(adj[2*WORD_W-1:WORD_W]));
                end
            end
        end
    end

    // stage 6: recombine halves
    logic signed [DOT_W-1:0] r6_pr [4][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int g = 0; g < 4; g++) begin
                for (int t = 0; t < 3; t++) begin
                    r6_pr[g][t] <= (DOT_W'(r5_ph[g][t]) <<< WORD_W) + DOT_W'(r5_pl[g][t]);
                end
            end
        end
    end

    // stage 7: determinant and numerators
    logic signed [DOT_W-1:0] sums [4];
    logic signed [DOT_W-1:0] r7_n [4];
    logic                    r7_sing;

    always_comb begin
        for (int g = 0; g < 4; g++) begin
            sums[g] = r6_pr[g][0] + r6_pr[g][1] + r6_pr[g][2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_n    <= sums;
            r7_sing <= (sums[0] == '0);
        end
    end

    // dividers, one per coordinate
    logic signed [WORD_W-1:0] quo [3];

    for (genvar c = 0; c < 3; c++) begin : g_div
        slt_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r7_n[c+1]),
            .i_den (r7_n[0]),
            .o_quo (quo[c])
        );
    end

    // singular flag delayed to match the dividers
    logic [DIV_LAT-1:0] r_sd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd <= {r_sd[DIV_LAT-2:0], r7_sing};
        end
    end

    t_result last;

    always_comb begin
        last.sing = r_sd[DIV_LAT-1];
        last.x    = last.sing ? '0 : quo[0];
        last.y    = last.sing ? '0 : quo[1];
        last.z    = last.sing ? '0 : quo[2];
    end

    // output register with skid stage
    t_result r_out, r_skid;
    logic    r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_out_ready) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || i_out_ready) begin
            r_out_v <= r_vld[TOT-1];
        end else if (r_vld[TOT-1]) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (i_out_ready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || i_out_ready) begin
            r_out <= last;
        end else begin
            r_skid <= last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_point_x   = r_out.x;
    assign o_point_y   = r_out.y;
    assign o_point_z   = r_out.z;
    assign o_singular  = r_out.sing;

    // checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid stage holds an item while the output register is empty");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_command == CMD_LOAD |=> !r_vld[0])
        else $error("load item entered the pixel pipeline");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_singular |-> o_point_x == '0 && o_point_y == '0 && o_point_z == '0)
        else $error("singular result with nonzero coordinates");

endmodule

`default_nettype wire

[src/slt_div.sv]
// ----------------------------------------------------------------------------
// slt_div: pipelined rounding divider
// Gives round(num * 2^F / den), ties away from zero, saturated to 32 bits.
// One quotient bit per restoring stage; a new item can enter every enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_div #(
    parameter int FRAC_BITS = slt_pkg::DEF_FRAC_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic signed [slt_pkg::DOT_W-1:0] i_num,
    input  wire logic signed [slt_pkg::DOT_W-1:0] i_den,
    output logic signed [slt_pkg::WORD_W-1:0]     o_quo
);
    import slt_pkg::*;

    localparam int MW = DOT_W;
    localparam int RW = MW + FRAC_BITS + QUO_W + 2;

    // stage A: magnitudes and sign
    logic [MW-1:0] r_nmag, r_dmag;
    logic          r_neg_a;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nmag  <= i_num[MW-1] ? MW'(-i_num) : MW'(i_num);
            r_dmag  <= i_den[MW-1] ? MW'(-i_den) : MW'(i_den);
            r_neg_a <= i_num[MW-1] ^ i_den[MW-1];
        end
    end

    // stage B: shifted dividend with half divisor added, doubled divisor
    logic [RW-1:0] r_n_b, r_d_b;
    logic          r_neg_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n_b   <= (RW'(r_nmag) << (FRAC_BITS + 1)) + RW'(r_dmag);
            r_d_b   <= RW'(r_dmag) << 1;
            r_neg_b <= r_neg_a;
        end
    end

    // stage C and bit stages: index 0 holds the overflow check
    logic [RW-1:0]    r_rem [QUO_W+1];
    logic [RW-1:0]    r_d   [QUO_W+1];
    logic [QUO_W-1:0] r_q   [QUO_W+1];
    logic             r_neg [QUO_W+1];
    logic             r_ovf [QUO_W+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= r_n_b;
            r_d[0]   <= r_d_b;
            r_q[0]   <= '0;
            r_neg[0] <= r_neg_b;
            r_ovf[0] <= r_n_b >= (r_d_b << QUO_W);
        end
    end

    // restoring steps, most significant quotient bit first
    for (genvar j = 1; j <= QUO_W; j++) begin : g_step
        localparam int K = QUO_W - j;
        logic [RW-1:0] sh;
        logic          take;
        assign sh   = r_d[j-1] << K;
        assign take = r_rem[j-1] >= sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= take ? r_rem[j-1] - sh : r_rem[j-1];
                r_d[j]   <= r_d[j-1];
                r_q[j]   <= {r_q[j-1][QUO_W-2:0], take};
                r_neg[j] <= r_neg[j-1];
                r_ovf[j] <= r_ovf[j-1];
            end
        end
    end

    // saturate and apply sign
    logic [QUO_W:0] lim, qmag;

    always_comb begin
        lim  = r_neg[QUO_W] ? (QUO_W+1)'(1) << (QUO_W - 1)
                            : ((QUO_W+1)'(1) << (QUO_W - 1)) - 1'b1;
        qmag = (r_ovf[QUO_W] || ({1'b0, r_q[QUO_W]} > lim)) ? lim : {1'b0, r_q[QUO_W]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quo <= r_neg[QUO_W] ? WORD_W'(-qmag) : WORD_W'(qmag);
        end
    end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for structured light triangulation
// Streams calibration loads and pixel items through the block with random
// gaps on the input side and random stalls on the output side. A local
// model of the 3x3 adjugate solve predicts X, Y, Z and the singular flag
// for every pixel, and the results are checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import slt_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic        cmd;
        logic [4:0]  idx;
        logic [31:0] val;
        logic [11:0] col;
        logic [11:0] row;
        logic [31:0] ph;
    } t_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_command = CMD_LOAD;
    logic [CAL_IDX_W-1:0] i_coef_index = '0;
    logic signed [WORD_W-1:0] i_coef_value = '0;
    logic [11:0] i_pixel_column = '0;
    logic [11:0] i_pixel_row = '0;
    logic signed [WORD_W-1:0] i_phase_value = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready, o_out_valid, o_singular;
    logic signed [WORD_W-1:0] o_point_x, o_point_y, o_point_z;

    structured_light_triangulation i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_command(i_command), .i_coef_index(i_coef_index),
        .i_coef_value(i_coef_value), .i_pixel_column(i_pixel_column),
        .i_pixel_row(i_pixel_row), .i_phase_value(i_phase_value),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_point_x(o_point_x), .o_point_y(o_point_y),
        .o_point_z(o_point_z), .o_singular(o_singular)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_item   pending_items[$];
    t_result expected_points[$];
    logic signed [31:0] calib[NUM_WORDS];
    int errors = 0;
    int n_pixels = 0;
    int n_singular = 0;
    int n_loads = 0;
    bit no_idle = 1'b0;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic longint clamp32(longint v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    // product with phase, rounded back to FRAC_BITS (floor after half add)
    function automatic longint round_frac(longint x);
        return (x + (64'sd1 <<< (DEF_FRAC_BITS - 1))) >>> DEF_FRAC_BITS;
    endfunction

    // round(num * 2^F / den), ties away from zero, saturated
    function automatic logic [31:0] scaled_quotient(logic signed [127:0] num,
                                                    logic signed [127:0] den);
        logic [159:0] n, d, q;
        logic         neg;
        logic [159:0] lim;
        neg = num[127] ^ den[127];
        n = 160'(num[127] ? -num : num);
        d = 160'(den[127] ? -den : den);
        q = ((n << (DEF_FRAC_BITS + 1)) + d) / (d << 1);
        lim = neg ? 160'h8000_0000 : 160'h7FFF_FFFF;
        if (q > lim) q = lim;
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic t_result triangulate_point(t_item it);
        t_result r;
        longint u, v, p;
        longint m[NUM_WORDS];
        logic signed [127:0] c11, c12, c13, c21, c22, c23, c31, c32, c33;
        logic signed [127:0] d1, d2, d3;
        // adjugate entries are 64-bit minors and wrap at that width
        longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
        logic signed [127:0] det;
        for (int k = 0; k < NUM_WORDS; k++) m[k] = calib[k];
        u = longint'(it.col) + 1;
        v = longint'(it.row) + 1;
        p = longint'(signed'(it.ph));
        c11 = clamp32(m[0] - m[8] * u);
        c12 = clamp32(m[1] - m[9] * u);
        c13 = clamp32(m[2] - m[10] * u);
        c21 = clamp32(m[4] - m[8] * v);
        c22 = clamp32(m[5] - m[9] * v);
        c23 = clamp32(m[6] - m[10] * v);
        c31 = clamp32(m[12] - round_frac(m[16] * p));
        c32 = clamp32(m[13] - round_frac(m[17] * p));
        c33 = clamp32(m[14] - round_frac(m[18] * p));
        d1 = clamp32(m[11] * u - m[3]);
        d2 = clamp32(m[11] * v - m[7]);
        d3 = clamp32(round_frac(m[19] * p) - m[15]);
        a11 = 64'(c22 * c33 - c23 * c32);
        a12 = 64'(c13 * c32 - c12 * c33);
        a13 = 64'(c12 * c23 - c13 * c22);
        a21 = 64'(c23 * c31 - c21 * c33);
        a22 = 64'(c11 * c33 - c13 * c31);
        a23 = 64'(c13 * c21 - c11 * c23);
        a31 = 64'(c21 * c32 - c22 * c31);
        a32 = 64'(c12 * c31 - c11 * c32);
        a33 = 64'(c11 * c22 - c12 * c21);
        det = c11 * a11 + c12 * a21 + c13 * a31;
        if (det == 0) begin
            r.x = '0;
            r.y = '0;
            r.z = '0;
            r.sing = 1'b1;
        end else begin
            r.x = scaled_quotient(d1 * a11 + d2 * a12 + d3 * a13, det);
            r.y = scaled_quotient(d1 * a21 + d2 * a22 + d3 * a23, det);
            r.z = scaled_quotient(d1 * a31 + d2 * a32 + d3 * a33, det);
            r.sing = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_load(int idx, logic [31:0] val);
        t_item it;
        it.cmd = CMD_LOAD;
        it.idx = 5'(idx);
        it.val = val;
        it.col = 12'($urandom);
        it.row = 12'($urandom);
        it.ph = $urandom;
        pending_items.push_back(it);
    endfunction

    function automatic void push_pixel(logic [11:0] col, logic [11:0] row,
                                       logic [31:0] ph);
        t_item it;
        it.cmd = CMD_PIXEL;
        it.idx = 5'($urandom);
        it.val = $urandom;
        it.col = col;
        it.row = row;
        it.ph = ph;
        pending_items.push_back(it);
    endfunction

    // calibration word in a plausible range, or fully random
    function automatic logic [31:0] cal_word(int style);
        case (style)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            default: return 32'($signed($urandom_range(0, 1 << 14)) - (1 << 13));
        endcase
    endfunction

    function automatic logic [31:0] phase_word();
        case ($urandom_range(0, 3))
            0: return $urandom;
            default: return 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Item sequence
    // ------------------------------------------------------------------
    initial begin
        int style;
        // directed: all words zero gives a singular system
        for (int k = 0; k < NUM_WORDS; k++) push_load(k, 32'h0);
        push_pixel(12'd0, 12'd0, 32'h0);
        // loads above the last index are dropped
        push_load(20, 32'h1234_5678);
        push_load(31, 32'hFFFF_FFFF);
        push_pixel(12'hFFF, 12'hFFF, 32'h8000_0000);
        // extreme words
        for (int k = 0; k < NUM_WORDS; k++)
            push_load(k, (k % 3 == 0) ? 32'h7FFF_FFFF :
                         (k % 3 == 1) ? 32'h8000_0000 : 32'h0001_0000);
        push_pixel(12'd0, 12'hFFF, 32'h7FFF_FFFF);
        push_pixel(12'hFFF, 12'd0, 32'h8000_0000);
        push_pixel(12'h555, 12'hAAA, 32'h0);

        // random phases: reload calibration, then a stream of pixels
        while (pending_items.size() < 1050) begin
            style = $urandom_range(0, 5);
            for (int k = 0; k < NUM_WORDS; k++) begin
                // style 5 zeroes the camera's third column, so c13 and c23 are zero
                if (style == 5 && (k == 2 || k == 6 || k == 10))
                    push_load(k, 32'h0);
                else
                    push_load(k, cal_word(style % 3));
            end
            repeat ($urandom_range(20, 90)) begin
                if ($urandom_range(0, 19) == 0)
                    push_load($urandom_range(0, 31), cal_word($urandom_range(0, 2)));
                else
                    push_pixel(12'($urandom), 12'($urandom), phase_word());
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: presents items with random gaps, predicts on acceptance
    // ------------------------------------------------------------------
    int in_gap = 0;
    always @(posedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (i_command == CMD_PIXEL) begin
                    it.col = i_pixel_column;
                    it.row = i_pixel_row;
                    it.ph = i_phase_value;
                    expected_points.push_back(triangulate_point(it));
                    n_pixels++;
                end else begin
                    if (i_coef_index < NUM_WORDS) calib[i_coef_index] = i_coef_value;
                    n_loads++;
                end
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0 || pending_items.size() == 0) begin
                    if (in_gap > 0) in_gap--;
                    i_in_valid <= 1'b0;
                end else begin
                    it = pending_items.pop_front();
                    i_in_valid <= 1'b1;
                    i_command <= it.cmd;
                    i_coef_index <= it.idx;
                    i_coef_value <= it.val;
                    i_pixel_column <= it.col;
                    i_pixel_row <= it.row;
                    i_phase_value <= it.ph;
                    if (!no_idle)
                        in_gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40)
                               : ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random backpressure, in-order compare
    // ------------------------------------------------------------------
    int out_stall = 0;
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_points.size() == 0) begin
                    $error("result with no pixel outstanding");
                    errors++;
                end else begin
                    exp_r = expected_points.pop_front();
                    if (exp_r.sing) n_singular++;
                    if (o_point_x !== exp_r.x) begin
                        $error("point_x expected %h got %h", exp_r.x, o_point_x);
                        errors++;
                    end
                    if (o_point_y !== exp_r.y) begin
                        $error("point_y expected %h got %h", exp_r.y, o_point_y);
                        errors++;
                    end
                    if (o_point_z !== exp_r.z) begin
                        $error("point_z expected %h got %h", exp_r.z, o_point_z);
                        errors++;
                    end
                    if (o_singular !== exp_r.sing) begin
                        $error("singular expected %b got %b", exp_r.sing, o_singular);
                        errors++;
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!no_idle)
                    out_stall = ($urandom_range(0, 24) == 0) ? $urandom_range(10, 60)
                              : ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            end
        end
    end

    // toggle idle-free stretches now and then
    always @(posedge i_clk) begin
        if (i_rst_n && $urandom_range(0, 299) == 0) no_idle <= !no_idle;
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no item moving on either side
    // ------------------------------------------------------------------
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (pending_items.size() == 0 && expected_points.size() == 0 && !i_in_valid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Reset and end of run
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wait (pending_items.size() == 0 && !i_in_valid && expected_points.size() == 0);
        repeat (100) @(posedge i_clk);
        if (expected_points.size() != 0) begin
            $error("%0d results never arrived", expected_points.size());
            errors++;
        end
        $display("covered %0d loads and %0d pixels, %0d of them singular",
                 n_loads, n_pixels, n_singular);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
